// ===== hw/rtl/tlcc_pkg.sv =====
`timescale 1ns / 1ps
package tlcc_pkg;

  localparam int NUM_SETS  = 16;
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int L2_WAYS   = 8;
  localparam int WAY_BITS  = $clog2(L2_WAYS);
  localparam int ADDR_BITS = 16;
  localparam int DATA_BITS = 32;
  localparam int TAG_BITS  = ADDR_BITS - SET_BITS;
  localparam int AGE_BITS  = WAY_BITS;
  localparam int CNT_BITS  = 32;

  localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(L2_WAYS - 1);

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [1:0] {
    LVL_L1   = 2'd0,
    LVL_L2   = 2'd1,
    LVL_MISS = 2'd2
  } hit_level_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic                 func;
    logic [ADDR_BITS-1:0] address;
    logic [DATA_BITS-1:0] data;
  } req_t;

  typedef struct packed {
    logic [1:0]           hit_level;
    logic [DATA_BITS-1:0] read_data;
    logic                 mem_write;
    logic [ADDR_BITS-1:0] mem_address;
    logic [DATA_BITS-1:0] mem_data;
    logic [CNT_BITS-1:0]  l1_access_count;
    logic [CNT_BITS-1:0]  l1_miss_count;
    logic [CNT_BITS-1:0]  l2_access_count;
    logic [CNT_BITS-1:0]  l2_miss_count;
  } rsp_t;

  typedef struct packed {
    logic                 valid;
    logic [TAG_BITS-1:0]  tag;
    logic [DATA_BITS-1:0] word;
    logic [AGE_BITS-1:0]  age;
  } way_t;

  typedef way_t [L2_WAYS-1:0] l2_row_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [DATA_BITS-1:0] word;
  } l1_line_t;

  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] victim;
  } look_t;

endpackage

// ===== hw/rtl/tlcc_ram.sv =====
`timescale 1ns / 1ps
module tlcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tlcc_lookup.sv =====
`timescale 1ns / 1ps
module tlcc_lookup (
  input  tlcc_pkg::l2_row_t                 row,
  input  logic [tlcc_pkg::TAG_BITS-1:0]     tag,
  output tlcc_pkg::look_t                   look
);
  import tlcc_pkg::*;

  always_comb begin
    logic                found_inv;
    logic [WAY_BITS-1:0] inv_way;
    logic [WAY_BITS-1:0] old_way;
    look      = '0;
    found_inv = 1'b0;
    inv_way   = '0;
    old_way   = '0;
    // lowest-index matching way wins
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (row[w].valid && row[w].tag == tag) begin
        look.hit     = 1'b1;
        look.hit_way = WAY_BITS'(w);
      end
      if (!row[w].valid) begin
        found_inv = 1'b1;
        inv_way   = WAY_BITS'(w);
      end
    end
    // lowest age, lowest index on a tie
    for (int w = 1; w < L2_WAYS; w++) begin
      if (row[w].age < row[old_way].age) begin
        old_way = WAY_BITS'(w);
      end
    end
    look.victim = found_inv ? inv_way : old_way;
  end

endmodule

// ===== hw/rtl/two_level_exclusive_cache_controller_unit.sv =====
`timescale 1ns / 1ps
// channel   | handshake           | payload
// request   | start in, busy out  | req (func, address, data)
// result    | done out (strobe)   | rsp (hit level, data, write-through, counts)
//
// each request goes through accept plus memory read, way lookup, then update;
// the result strobe follows in the next cycle, when a new request may enter.
// the set row read from the l1 and l2 memories limits the rate to one access
// in flight. synchronous reset clears l1/l2 valid state and the counters.
// the result is shown for one cycle and cannot be stalled.
module two_level_exclusive_cache_controller_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tlcc_pkg::req_t req,
  output logic           done,
  output tlcc_pkg::rsp_t rsp
);
  import tlcc_pkg::*;

  state_e state, state_next;
  req_t   req_q;
  logic   accept, upd;

  logic [NUM_SETS-1:0] l1_valid;
  logic [NUM_SETS-1:0] l2_row_init;
  logic                row_init_q;

  logic [CNT_BITS-1:0] cnt [4];
  logic [CNT_BITS-1:0] cnt_next [4];

  l1_line_t l1_rdata, l1_wdata;
  l2_row_t  l2_rdata, l2_wdata, row_eff;
  logic     l1_we, l2_we, l1_set;
  look_t    look_c, look_q;
  rsp_t     rsp_next;

  logic [SET_BITS-1:0] set_q;
  logic [TAG_BITS-1:0] tag_q;

  assign set_q = req_q.address[SET_BITS-1:0];
  assign tag_q = req_q.address[ADDR_BITS-1:SET_BITS];

  always_comb begin
    case (state)
      ST_IDLE: state_next = (start) ? ST_LOOK : ST_IDLE;
      ST_LOOK: state_next = ST_UPD;
      ST_UPD:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != ST_IDLE);
    accept = start && (state == ST_IDLE);
    upd    = (state == ST_UPD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  tlcc_ram #(.WIDTH($bits(l1_line_t)), .DEPTH(NUM_SETS)) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (set_q),
    .wdata (l1_wdata),
    .re    (accept),
    .raddr (req.address[SET_BITS-1:0]),
    .rdata (l1_rdata)
  );

  tlcc_ram #(.WIDTH($bits(l2_row_t)), .DEPTH(NUM_SETS)) u_l2_ram (
    .clk   (clk),
    .we    (l2_we),
    .waddr (set_q),
    .wdata (l2_wdata),
    .re    (accept),
    .raddr (req.address[SET_BITS-1:0]),
    .rdata (l2_rdata)
  );

  // a row never written reads as all invalid with zero ages
  assign row_eff = row_init_q ? l2_rdata : '0;

  tlcc_lookup u_lookup (
    .row  (row_eff),
    .tag  (tag_q),
    .look (look_c)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= req;
      row_init_q <= l2_row_init[req.address[SET_BITS-1:0]];
    end
    if (state == ST_LOOK) begin
      look_q <= look_c;
    end
  end

  function automatic l2_row_t make_recent(l2_row_t row, logic [WAY_BITS-1:0] way);
    l2_row_t             r;
    logic [AGE_BITS-1:0] ref_age;
    r       = row;
    ref_age = row[way].age;
    for (int j = 0; j < L2_WAYS; j++) begin
      if (r[j].valid && r[j].age > ref_age) begin
        r[j].age = r[j].age - 1'b1;
      end
    end
    r[way].age = AGE_MAX;
    return r;
  endfunction

  always_comb begin
    logic     l1v, is_wr;
    l2_row_t  r;
    logic [DATA_BITS-1:0] cached;
    l1v      = l1_valid[set_q];
    is_wr    = (req_q.func == FUNC_WRITE);
    r        = row_eff;
    cached   = row_eff[look_q.hit_way].word;
    l1_we    = 1'b0;
    l2_we    = 1'b0;
    l1_set   = 1'b0;
    l1_wdata = '{tag: tag_q, word: req_q.data};
    l2_wdata = row_eff;
    for (int i = 0; i < 4; i++) cnt_next[i] = cnt[i];
    cnt_next[0] = cnt[0] + 1'b1;
    rsp_next = '0;
    rsp_next.hit_level = LVL_L1;
    if (l1v && l1_rdata.tag == tag_q) begin
      if (is_wr) begin
        l1_we = 1'b1;
      end else begin
        rsp_next.read_data = l1_rdata.word;
      end
    end else begin
      cnt_next[1] = cnt[1] + 1'b1;
      cnt_next[2] = cnt[2] + 1'b1;
      if (look_q.hit) begin
        // swap l1 line with the hit way
        rsp_next.hit_level = LVL_L2;
        r[look_q.hit_way].valid = l1v;
        r[look_q.hit_way].tag   = l1_rdata.tag;
        r[look_q.hit_way].word  = l1_rdata.word;
        l2_wdata = make_recent(r, look_q.hit_way);
        l2_we    = 1'b1;
        l1_we    = 1'b1;
        l1_set   = 1'b1;
        l1_wdata.word = is_wr ? req_q.data : cached;
        if (!is_wr) rsp_next.read_data = cached;
      end else begin
        rsp_next.hit_level = LVL_MISS;
        cnt_next[3] = cnt[3] + 1'b1;
        if (!is_wr) begin
          rsp_next.read_data = req_q.data;
          if (l1v) begin
            r[look_q.victim].valid = 1'b1;
            r[look_q.victim].tag   = l1_rdata.tag;
            r[look_q.victim].word  = l1_rdata.word;
            l2_wdata = make_recent(r, look_q.victim);
            l2_we    = 1'b1;
          end
          l1_we  = 1'b1;
          l1_set = 1'b1;
        end
      end
    end
    if (is_wr) begin
      rsp_next.mem_write   = 1'b1;
      rsp_next.mem_address = req_q.address;
      rsp_next.mem_data    = req_q.data;
    end
    rsp_next.l1_access_count = cnt_next[0];
    rsp_next.l1_miss_count   = cnt_next[1];
    rsp_next.l2_access_count = cnt_next[2];
    rsp_next.l2_miss_count   = cnt_next[3];
    l1_we = l1_we && upd;
    l2_we = l2_we && upd;
    l1_set = l1_set && upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid    <= '0;
      l2_row_init <= '0;
      done        <= 1'b0;
      for (int i = 0; i < 4; i++) cnt[i] <= '0;
    end else begin
      done <= upd;
      if (l1_set) l1_valid[set_q] <= 1'b1;
      if (l2_we) l2_row_init[set_q] <= 1'b1;
      if (upd) begin
        for (int i = 0; i < 4; i++) cnt[i] <= cnt_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== hw/rtl/tlcc_checker.sv =====
`timescale 1ns / 1ps
module tlcc_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input tlcc_pkg::req_t req,
  input logic           done,
  input tlcc_pkg::rsp_t rsp
);
  import tlcc_pkg::*;

  a_done_three: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done) else $error("result not delivered in time");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe repeated");

  a_rd_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.mem_write) |-> (rsp.mem_data == '0 && rsp.mem_address == '0))
    else $error("write-through fields set on read");

endmodule

bind two_level_exclusive_cache_controller_unit tlcc_checker u_tlcc_checker (.*);
